[rtl/core/mco_pkg.sv]
// Matrix chain order package: request types and shared constants.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package mco_pkg;

  // Defaults for the top-level parameters
  localparam int MCO_MAX_MATRICES = 8;
  localparam int MCO_DIM_WIDTH    = 16;

  // Fixed field widths of the request channels
  localparam int DIM_W  = 16;
  localparam int IDX_OW = 4;
  localparam int COST_W = 64;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Input request: one chain dimension
  typedef struct packed {
    logic [DIM_W-1:0] dim;
    logic             last;
  } in_req_t;

  // Output request: one table entry or a status result
  typedef struct packed {
    logic [IDX_OW-1:0] row;
    logic [IDX_OW-1:0] col;
    logic [COST_W-1:0] cost;
    logic [IDX_OW-1:0] split;
    logic              final_res;
    logic              bad_length;
  } out_req_t;

endpackage

[rtl/core/matrix_chain_order_dp.sv]
// Matrix chain order solver: dimension store, cost/split table memory, DP sequencer.
// Depends on mco_pkg for request types and constants.
`timescale 1ns / 1ps

// Channel  Ports                          Payload    Direction
// input    in_valid / in_ready / in_req   in_req_t   one dimension per request
// output   out_valid / out_ready / out_req out_req_t one table entry per request
//
// The last dimension starts the fill: for each pair (i,j), states LDI and LDJ fetch
// d[i-1] and d[j], then every split k runs through states RD, MUL1, MUL2 and CMP
// (read, multiply, multiply, add-compare) through the shared multiplier pair.
// Results then leave one per pair through table read port A, in states ERD and EWAIT.
// Bad-length and single-matrix chains give one result. Reset needs no clearing pass.
// A stalled output holds its register; new dimensions are taken only while idle.

module matrix_chain_order_dp
  import mco_pkg::*;
#(
  parameter int MAX_MATRICES = MCO_MAX_MATRICES,
  parameter int DIM_WIDTH    = MCO_DIM_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_req
);

  localparam int CNT_W  = $clog2(MAX_MATRICES + 2);
  localparam int IDX_W  = $clog2(MAX_MATRICES + 1);
  localparam int CA_W   = $clog2(MAX_MATRICES * MAX_MATRICES);
  localparam int CDEPTH = MAX_MATRICES * MAX_MATRICES;
  localparam int P1_W   = 2 * DIM_WIDTH;
  localparam int P_W    = 3 * DIM_WIDTH;
  localparam int WORD_W = IDX_W + COST_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ONE   = 4'd1;
  localparam logic [3:0] ST_LDI   = 4'd2;
  localparam logic [3:0] ST_LDJ   = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_MUL1  = 4'd5;
  localparam logic [3:0] ST_MUL2  = 4'd6;
  localparam logic [3:0] ST_CMP   = 4'd7;
  localparam logic [3:0] ST_ERD   = 4'd8;
  localparam logic [3:0] ST_EWAIT = 4'd9;

  // Table cell address for subchain (r,c), both counted from 1
  function automatic logic [CA_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return CA_W'((int'(r) - 1) * MAX_MATRICES + int'(c) - 1);
  endfunction

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  // Control registers
  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] diag_r, diag_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             one_bad_r, one_bad_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [DIM_WIDTH-1:0] di_r, dj_r;
  logic [P1_W-1:0]      p1_r;
  logic [P_W-1:0]       prod_r;
  logic [COST_W-1:0]    s1_r, best_r;
  logic [IDX_W-1:0]     bestk_r;
  out_req_t             out_req_r;

  // Memories
  logic [DIM_WIDTH-1:0] dim_mem [MAX_MATRICES+1];
  logic [DIM_WIDTH-1:0] dim_q;
  logic [IDX_W-1:0]     dim_raddr;
  logic                 dim_we;

  logic [WORD_W-1:0] tbl_mem [CDEPTH];
  logic [WORD_W-1:0] qa, qb;
  logic [CA_W-1:0]   ra_addr, rb_addr, w_addr;
  logic              tbl_we;
  logic [WORD_W-1:0] tbl_wd;

  logic              in_acc, out_free, last_k, take, final_pair;
  logic [IDX_W-1:0]  k_inc;
  logic [COST_W-1:0] cand_v, best_sel, left_c, right_c;
  logic [IDX_W-1:0]  bestk_sel;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  assign k_inc      = IDX_W'(k_r + 1'b1);
  assign last_k     = (k_inc == j_r);
  assign final_pair = (j_r == n_r) && (IDX_W'(i_r + 1'b1) == n_r);

  // Candidate cost and running minimum; first minimum wins ties
  assign cand_v    = sat_add(s1_r, COST_W'(prod_r));
  assign take      = (k_r == i_r) || (cand_v < best_r);
  assign best_sel  = take ? cand_v : best_r;
  assign bestk_sel = take ? k_r : bestk_r;

  // Diagonal cells are zero and never stored
  assign left_c  = (k_r == i_r) ? '0 : qa[COST_W-1:0];
  assign right_c = last_k ? '0 : qb[COST_W-1:0];

  // Memory addressing
  assign dim_we   = in_acc && (cnt_r <= CNT_W'(MAX_MATRICES));
  assign ra_addr  = (state_r == ST_ERD || state_r == ST_EWAIT) ? cell_addr(i_r, j_r)
                                                                 : cell_addr(i_r, k_r);
  assign rb_addr  = cell_addr(k_inc, j_r);
  assign w_addr   = cell_addr(i_r, j_r);
  assign tbl_we   = (state_r == ST_CMP) && last_k;
  assign tbl_wd   = {bestk_sel, best_sel};

  always_comb begin
    unique case (state_r)
      ST_LDI:  dim_raddr = IDX_W'(i_r - 1'b1);
      ST_LDJ:  dim_raddr = j_r;
      default: dim_raddr = k_r;
    endcase
  end

  // Dimension store
  always_ff @(posedge clk) begin
    if (dim_we) begin
      dim_mem[cnt_r[IDX_W-1:0]] <= DIM_WIDTH'(in_req.dim);
    end
    dim_q <= dim_mem[dim_raddr];
  end

  // Cost and split table: one write port, two read ports
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[w_addr] <= tbl_wd;
    end
    qa <= tbl_mem[ra_addr];
    qb <= tbl_mem[rb_addr];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    diag_nxt      = diag_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    one_bad_nxt   = one_bad_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_req.last) begin
            if (cnt_r < CNT_W'(MAX_MATRICES + 1)) begin
              cnt_nxt = CNT_W'(cnt_r + 1'b1);
            end
          end else begin
            cnt_nxt = '0;
            if (cnt_r == '0 || cnt_r > CNT_W'(MAX_MATRICES)) begin
              one_bad_nxt = 1'b1;
              state_nxt   = ST_ONE;
            end else if (cnt_r == CNT_W'(1)) begin
              one_bad_nxt = 1'b0;
              state_nxt   = ST_ONE;
            end else begin
              n_nxt     = cnt_r[IDX_W-1:0];
              diag_nxt  = IDX_W'(1);
              i_nxt     = IDX_W'(1);
              j_nxt     = IDX_W'(2);
              state_nxt = ST_LDI;
            end
          end
        end
      end
      ST_ONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_LDI: begin
        k_nxt     = i_r;
        state_nxt = ST_LDJ;
      end
      ST_LDJ:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_CMP;
      ST_CMP: begin
        if (!last_k) begin
          k_nxt     = k_inc;
          state_nxt = ST_RD;
        end else if (j_r < n_r) begin
          i_nxt     = IDX_W'(i_r + 1'b1);
          j_nxt     = IDX_W'(j_r + 1'b1);
          state_nxt = ST_LDI;
        end else if (IDX_W'(diag_r + 1'b1) < n_r) begin
          diag_nxt  = IDX_W'(diag_r + 1'b1);
          i_nxt     = IDX_W'(1);
          j_nxt     = IDX_W'(diag_r + 2'd2);
          state_nxt = ST_LDI;
        end else begin
          i_nxt     = IDX_W'(1);
          j_nxt     = IDX_W'(2);
          state_nxt = ST_ERD;
        end
      end
      ST_ERD:  state_nxt = ST_EWAIT;
      ST_EWAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (final_pair) begin
            state_nxt = ST_IDLE;
          end else if (j_r < n_r) begin
            j_nxt     = IDX_W'(j_r + 1'b1);
            state_nxt = ST_ERD;
          end else begin
            i_nxt     = IDX_W'(i_r + 1'b1);
            j_nxt     = IDX_W'(i_r + 2'd2);
            state_nxt = ST_ERD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      diag_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      one_bad_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      diag_r      <= diag_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      one_bad_r   <= one_bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Advance the multiply-add pipeline for one split candidate
  always_ff @(posedge clk) begin
    if (state_r == ST_LDJ) begin
      di_r <= dim_q;
    end
    if (state_r == ST_RD && k_r == i_r) begin
      dj_r <= dim_q;
    end
    if (state_r == ST_MUL1) begin
      p1_r <= P1_W'(di_r) * P1_W'(dim_q);
      s1_r <= sat_add(left_c, right_c);
    end
    if (state_r == ST_MUL2) begin
      prod_r <= P_W'(p1_r) * P_W'(dj_r);
    end
    if (state_r == ST_CMP) begin
      best_r  <= best_sel;
      bestk_r <= bestk_sel;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (state_r == ST_ONE && out_free) begin
      out_req_r.row        <= one_bad_r ? '0 : IDX_OW'(1);
      out_req_r.col        <= one_bad_r ? '0 : IDX_OW'(1);
      out_req_r.cost       <= '0;
      out_req_r.split      <= '0;
      out_req_r.final_res  <= 1'b1;
      out_req_r.bad_length <= one_bad_r;
    end else if (state_r == ST_EWAIT && out_free) begin
      out_req_r.row        <= IDX_OW'(i_r);
      out_req_r.col        <= IDX_OW'(j_r);
      out_req_r.cost       <= qa[COST_W-1:0];
      out_req_r.split      <= IDX_OW'(qa[WORD_W-1:COST_W]);
      out_req_r.final_res  <= final_pair;
      out_req_r.bad_length <= 1'b0;
    end
  end

endmodule

[rtl/core/mco_checker.sv]
// Port-level checker for the matrix chain order solver, bound to the top level.
// Depends on mco_pkg for the request types.
`timescale 1ns / 1ps

module mco_checker
  import mco_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input in_req_t  in_req,
  input logic     out_valid,
  input logic     out_ready,
  input out_req_t out_req
);

  // Drop any result on reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request valid after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_req))
    else $error("stalled result request changed");

  // Bad length gives one empty, final result
  a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.bad_length |-> out_req.final_res && out_req.row == '0 &&
      out_req.col == '0 && out_req.cost == '0 && out_req.split == '0)
    else $error("bad-length result carries data");

  // Split lies inside its subchain
  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_req.bad_length |-> out_req.row != '0 && out_req.row <= out_req.col &&
      (out_req.row == out_req.col ? out_req.split == '0 :
       (out_req.split >= out_req.row && out_req.split < out_req.col)))
    else $error("split outside subchain");

endmodule

bind matrix_chain_order_dp mco_checker u_mco_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_req   (out_req)
);

[test/matrix_chain_order_dp_checker.sv]
// Checker for the matrix chain order solver: watches both request channels,
// predicts the table entries of every chain and compares them in order.
// Depends on mco_pkg for the request types and widths.
`timescale 1ns / 1ps

module matrix_chain_order_dp_checker
  import mco_pkg::*;
#(
  parameter int MAX_MATRICES = MCO_MAX_MATRICES,
  parameter int DIM_WIDTH    = MCO_DIM_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_req_t out_req,
  output int       mismatches,
  output int       entries_left,
  output int       entries_checked
);

  localparam logic [DIM_W-1:0] DIM_MASK = DIM_W'((64'd1 << DIM_WIDTH) - 64'd1);

  // Shadow copy of the chain and the tables
  logic [DIM_W-1:0]  chain_dims [0:MAX_MATRICES];
  int                dims_seen;
  logic [COST_W-1:0] cost_tab   [1:MAX_MATRICES][1:MAX_MATRICES];
  logic [IDX_OW-1:0] split_tab  [1:MAX_MATRICES][1:MAX_MATRICES];
  out_req_t          pending_entries [$];

  function automatic logic [COST_W-1:0] add_sat(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  // Fill the tables for n matrices, then queue every pair i<j in row order
  function automatic void solve_chain(input int n);
    logic [COST_W-1:0] best;
    logic [COST_W-1:0] cand;
    logic [COST_W-1:0] prod;
    int                best_k;
    int                j;
    out_req_t          e;
    for (int i = 1; i <= n; i++) begin
      cost_tab[i][i]  = '0;
      split_tab[i][i] = '0;
    end
    for (int span = 1; span < n; span++) begin
      for (int i = 1; i + span <= n; i++) begin
        j      = i + span;
        best   = COST_MAX;
        best_k = i;
        for (int k = i; k < j; k++) begin
          prod = COST_W'(chain_dims[i-1]) * COST_W'(chain_dims[k]) * COST_W'(chain_dims[j]);
          cand = add_sat(add_sat(cost_tab[i][k], cost_tab[k+1][j]), prod);
          // first candidate always taken; later ones only when strictly lower
          if (k == i || cand < best) begin
            best   = cand;
            best_k = k;
          end
        end
        cost_tab[i][j]  = best;
        split_tab[i][j] = IDX_OW'(best_k);
      end
    end
    for (int i = 1; i < n; i++) begin
      for (int jj = i + 1; jj <= n; jj++) begin
        e            = '0;
        e.row        = IDX_OW'(i);
        e.col        = IDX_OW'(jj);
        e.cost       = cost_tab[i][jj];
        e.split      = split_tab[i][jj];
        e.final_res  = (i == n - 1) && (jj == n);
        pending_entries.push_back(e);
      end
    end
  endfunction

  // Store one dimension; the last one closes the chain
  function automatic void take_dimension(input in_req_t r);
    int       n;
    out_req_t e;
    if (dims_seen <= MAX_MATRICES) chain_dims[dims_seen] = r.dim & DIM_MASK;
    if (!r.last) begin
      if (dims_seen < MAX_MATRICES + 1) dims_seen++;
    end else begin
      n         = dims_seen;
      dims_seen = 0;
      e         = '0;
      e.final_res = 1'b1;
      if (n < 1 || n > MAX_MATRICES) begin
        e.bad_length = 1'b1;
        pending_entries.push_back(e);
      end else if (n == 1) begin
        e.row = IDX_OW'(1);
        e.col = IDX_OW'(1);
        pending_entries.push_back(e);
      end else begin
        solve_chain(n);
      end
    end
  endfunction

  // Watch both channels at each rising edge
  always @(posedge clk) begin : watch
    out_req_t want;
    if (!rst_n) begin
      dims_seen = 0;
      pending_entries.delete();
    end else begin
      if (in_valid && in_ready) take_dimension(in_req);
      if (out_valid && out_ready) begin
        if (pending_entries.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result row=%0d col=%0d cost=%0d split=%0d fin=%b bad=%b",
                     $time, out_req.row, out_req.col, out_req.cost, out_req.split,
                     out_req.final_res, out_req.bad_length);
          mismatches++;
        end else begin
          want = pending_entries.pop_front();
          entries_checked++;
          if (want.row !== out_req.row || want.col !== out_req.col ||
              want.cost !== out_req.cost || want.split !== out_req.split ||
              want.final_res !== out_req.final_res ||
              want.bad_length !== out_req.bad_length) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch exp row=%0d col=%0d cost=%0d split=%0d fin=%b bad=%b",
                       $time, want.row, want.col, want.cost, want.split,
                       want.final_res, want.bad_length);
              $display("%0t:          got row=%0d col=%0d cost=%0d split=%0d fin=%b bad=%b",
                       $time, out_req.row, out_req.col, out_req.cost, out_req.split,
                       out_req.final_res, out_req.bad_length);
            end
            mismatches++;
          end
        end
      end
    end
    entries_left = pending_entries.size();
  end

endmodule

[test/matrix_chain_order_dp_tb.sv]
// Top of the matrix chain order testbench: clock, reset, dimension requests
// and output back-pressure. Depends on mco_pkg, the solver and its checker.
`timescale 1ns / 1ps

module matrix_chain_order_dp_tb;
  import mco_pkg::*;

  localparam int MAX_M        = MCO_MAX_MATRICES;
  localparam int PHASE_ITEMS  = 38;
  localparam int HOLD_CYCLES  = 1000;
  localparam int TAIL_CYCLES  = 100;
  localparam int CYCLE_LIMIT  = 400000;

  // Dimension patterns for one chain
  localparam int DM_FULL    = 0;
  localparam int DM_SMALL   = 1;
  localparam int DM_EXTREME = 2;
  localparam int DM_SAME    = 3;
  localparam int DM_FIXED   = 4;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  in_req_t  in_req    = '0;
  logic     out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  out_req_t out_req;

  int mismatches;
  int entries_left;
  int entries_checked;

  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int chains_sent   = 0;
  int bad_chains    = 0;
  int cycles        = 0;

  matrix_chain_order_dp #(
    .MAX_MATRICES(MCO_MAX_MATRICES),
    .DIM_WIDTH   (MCO_DIM_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_req  (out_req)
  );

  matrix_chain_order_dp_checker #(
    .MAX_MATRICES(MCO_MAX_MATRICES),
    .DIM_WIDTH   (MCO_DIM_WIDTH)
  ) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_req        (out_req),
    .mismatches     (mismatches),
    .entries_left   (entries_left),
    .entries_checked(entries_checked)
  );

  always #5 clk = ~clk;

  // Output back-pressure: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Stop a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still outstanding", cycles, entries_left);
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one dimension request and hold it until accepted; returns at a falling edge
  task automatic send_dim(input logic [DIM_W-1:0] d, input logic lst);
    in_req_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    r.dim  = d;
    r.last = lst;
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Send a whole chain of n_dims dimensions, the last one flagged
  task automatic send_chain(input int n_dims, input int mode, input logic [DIM_W-1:0] fixed_v);
    logic [DIM_W-1:0] same_v;
    logic [DIM_W-1:0] d;
    same_v = DIM_W'($urandom);
    chains_sent++;
    if (n_dims - 1 < 1 || n_dims - 1 > MAX_M) bad_chains++;
    for (int t = 0; t < n_dims; t++) begin
      case (mode)
        DM_SMALL: d = DIM_W'($urandom_range(15));
        DM_EXTREME: begin
          case ($urandom_range(2))
            0:       d = '0;
            1:       d = DIM_W'(1);
            default: d = '1;
          endcase
        end
        DM_SAME:  d = same_v;
        DM_FIXED: d = fixed_v;
        default:  d = DIM_W'($urandom);
      endcase
      send_dim(d, t == n_dims - 1);
    end
  endtask

  // Random chain: mostly legal lengths, some empty or too long
  task automatic send_random_chain();
    int pick;
    int n_dims;
    pick = $urandom_range(99);
    if (pick < 6)
      n_dims = 1;
    else if (pick < 14)
      n_dims = MAX_M + 2 + $urandom_range(2);
    else if (pick < 57)
      n_dims = 1 + $urandom_range(MAX_M, MAX_M - 3);
    else
      n_dims = 1 + $urandom_range(MAX_M, 1);
    send_chain(n_dims, $urandom_range(DM_SAME), '0);
  endtask

  task automatic run_phase(input int send_idle, input int recv_stall);
    int start;
    idle_pct  = send_idle;
    stall_pct <= recv_stall;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) send_random_chain();
  endtask

  initial begin
    // Hold reset, release at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty chain, one matrix, largest dimensions, ties, zeros, too long
    send_chain(1, DM_FIXED, 16'h1234);
    send_chain(2, DM_FIXED, 16'hFFFF);
    send_chain(3, DM_FIXED, 16'hFFFF);
    send_chain(4, DM_FIXED, 16'h0001);
    send_chain(4, DM_FIXED, 16'h0000);
    send_chain(MAX_M + 2, DM_FIXED, 16'h00A5);

    // Random chains under each idling pattern
    run_phase(0, 0);
    run_phase(74, 0);
    run_phase(0, 74);
    run_phase(20, 20);

    // Block the output for a long stretch while full-length chains keep coming
    idle_pct      = 0;
    stall_pct     <= 0;
    hold_requests <= hold_requests + 1;
    send_chain(MAX_M + 1, DM_FIXED, 16'hFFFF);
    send_chain(MAX_M + 1, DM_FULL, '0);
    send_chain(MAX_M + 1, DM_FULL, '0);

    // Drain and watch for stray results
    in_valid <= 1'b0;
    while (entries_left != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d dimensions in %0d chains (%0d of bad length); %0d results checked",
             items_sent, chains_sent, bad_chains, entries_checked);
    $display("Idling: none, sender gaps, receiver stalls, both, and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatches == 0 && entries_left == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, entries_left);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/mco_pkg.sv
rtl/core/matrix_chain_order_dp.sv
rtl/core/mco_checker.sv
test/matrix_chain_order_dp_checker.sv
test/matrix_chain_order_dp_tb.sv
